FILE: hdl/bb3_pkg.sv
// Package for the 3x3 RGB box blur: frame size, pixel and request types,
// and the divide-by-nine helper. No dependencies.
`default_nettype none

package bb3_pkg;

  // Frame geometry (square frames, 4 to 4096 pixels a side)
  localparam int IMAGE_SIZE = 256;
  localparam int COL_W      = $clog2(IMAGE_SIZE);
  localparam int ROW_W      = $clog2(IMAGE_SIZE + 2);

  // Neighbourhood sum of nine 8-bit samples needs 12 bits
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  // ceil(2^16 / 9): exact quotient for every sum up to 9 * 255
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } px_t;

  // Input request
  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       flush;
  } pix_t;

  // Output request
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } blur_t;

  // Per-request control carried from the position counters to the window
  typedef struct packed {
    logic             valid;
    logic             pixel_part;
    logic             last_item;
    logic             emit_a;        // finish previous row's last pixel
    logic             emit_b;        // normal result from the shifted window
    logic             col_one;       // left edge clamp
    logic             top_clamp;
    logic             bottom_clamp;
    logic [COL_W-1:0] col;
  } ctl_t;

  // Nine selected neighbourhood pixels, raster order
  typedef struct packed {
    logic          valid;
    logic          frame_end;
    px_t [8:0]     px;
  } taps_t;

  // Divide a neighbourhood sum by nine through the reciprocal
  function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+RECIP_W-1:0] p;
    p = {{RECIP_W{1'b0}}, s} * {{SUM_W{1'b0}}, RECIP_9};
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bb3_line_ram.sv
// Simple dual-port line memory: one write port, one read port with
// registered read data. Generic; no package dependency.
`default_nettype none

module bb3_line_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bb3_window.sv
// 3x3 window register: shifts in one column per request and selects the
// nine clamped neighbours of the result. Depends on bb3_pkg.
`default_nettype none

module bb3_window (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  bb3_pkg::ctl_t  ctl,
  input  bb3_pkg::px_t   pixel,
  input  bb3_pkg::px_t   top,
  input  bb3_pkg::px_t   mid,
  output bb3_pkg::taps_t taps
);
  import bb3_pkg::*;

  px_t        win  [3][3];   // [row][column], row 0 oldest, column 2 newest
  px_t        nw   [3][3];
  px_t        src  [3][3];
  px_t        bottom;
  logic [1:0] rsel [3];
  logic [1:0] csel [3];
  px_t [8:0]  sel;

  // Build the shifted window and pick the neighbourhood
  always_comb begin
    bottom = ctl.pixel_part ? pixel : mid;
    for (int k = 0; k < 3; k++) begin
      nw[k][0] = win[k][1];
      nw[k][1] = win[k][2];
    end
    nw[0][2] = top;
    nw[1][2] = mid;
    nw[2][2] = bottom;

    // The end-of-row result reads the window before this request's shift
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        src[i][j] = ctl.emit_a ? win[i][j] : nw[i][j];
      end
    end

    // Clamp rows at the top and bottom edges
    rsel[0] = ctl.top_clamp ? 2'd1 : 2'd0;
    rsel[1] = 2'd1;
    rsel[2] = ctl.bottom_clamp ? 2'd1 : 2'd2;

    // Clamp columns: right edge for the end-of-row result, left edge otherwise
    if (ctl.emit_a) begin
      csel[0] = 2'd1;
      csel[1] = 2'd2;
      csel[2] = 2'd2;
    end else begin
      csel[0] = ctl.col_one ? 2'd1 : 2'd0;
      csel[1] = 2'd1;
      csel[2] = 2'd2;
    end

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sel[i*3 + j] = src[rsel[i]][csel[j]];
      end
    end
  end

  // Advance the window on every request that is not the final drain request
  always_ff @(posedge clk) begin
    if (en && ctl.valid && !ctl.last_item) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= nw[i][j];
        end
      end
    end
  end

  // Register the selected neighbourhood
  always_ff @(posedge clk) begin
    if (rst) begin
      taps.valid <= 1'b0;
    end else if (en) begin
      taps.valid <= ctl.valid && (ctl.emit_a || ctl.emit_b);
    end
    if (en) begin
      taps.frame_end <= ctl.last_item;
      taps.px        <= sel;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bb3_average.sv
// Neighbourhood sum and divide by nine, ending in the output register.
// Depends on bb3_pkg.
`default_nettype none

module bb3_average (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  bb3_pkg::taps_t taps,
  output logic           blur_valid,
  output bb3_pkg::blur_t blur
);
  import bb3_pkg::*;

  logic             sum_valid;
  logic             sum_end;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [SUM_W-1:0] add_r;
  logic [SUM_W-1:0] add_g;
  logic [SUM_W-1:0] add_b;

  // Add the nine samples of each channel
  always_comb begin
    add_r = '0;
    add_g = '0;
    add_b = '0;
    for (int k = 0; k < 9; k++) begin
      add_r = add_r + {{(SUM_W-8){1'b0}}, taps.px[k].red};
      add_g = add_g + {{(SUM_W-8){1'b0}}, taps.px[k].green};
      add_b = add_b + {{(SUM_W-8){1'b0}}, taps.px[k].blue};
    end
  end

  // Hold the sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= taps.valid;
    end
    if (en) begin
      sum_end <= taps.frame_end;
      sum_r   <= add_r;
      sum_g   <= add_g;
      sum_b   <= add_b;
    end
  end

  // Divide and load the output register; it holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      blur_valid <= 1'b0;
    end else if (en) begin
      blur_valid <= sum_valid;
    end
    if (en) begin
      blur.out_red   <= div9(sum_r);
      blur.out_green <= div9(sum_g);
      blur.out_blue  <= div9(sum_b);
      blur.frame_end <= sum_end;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/box_blur_3x3_rgb.sv
// 3x3 box blur of square RGB frames. Takes one request per clock unless
// stalled; a result, if any, passes the request, window and sum registers
// to the output register. Results lag the pixel stream by one row plus one
// pixel of requests. The line memory does one read and one write per clock
// unless stalled. Reset clears the position counters and pipeline valid
// flags; line memory and window are not cleared and need no clearing pass.
`default_nettype none

module box_blur_3x3_rgb (
  input  logic           clk,
  input  logic           rst,
  input  logic           pix_valid,
  output logic           pix_stall,
  input  bb3_pkg::pix_t  pix,
  output logic           blur_valid,
  input  logic           blur_stall,
  output bb3_pkg::blur_t blur
);
  import bb3_pkg::*;

  logic             en;
  logic             accept;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             last_item;
  ctl_t             ctl_next;
  ctl_t             ctl;
  px_t              pixel;
  logic [47:0]      rd_data;
  logic             wr_en;
  logic [47:0]      wr_data;
  taps_t            taps;

  // The whole pipeline moves unless a finished result is held back
  assign en        = !blur_valid || !blur_stall;
  assign pix_stall = !en;
  assign accept    = pix_valid && en;

  assign last_item = (row == ROW_W'(IMAGE_SIZE + 1));

  // Decode the role of the incoming request from its position
  always_comb begin
    ctl_next.valid        = accept;
    ctl_next.pixel_part   = (row < ROW_W'(IMAGE_SIZE));
    ctl_next.last_item    = last_item;
    ctl_next.emit_a       = (col == '0) && (row >= ROW_W'(2));
    ctl_next.emit_b       = (col != '0) && (row != '0) && !last_item;
    ctl_next.col_one      = (col == COL_W'(1));
    ctl_next.top_clamp    = ctl_next.emit_a ? (row == ROW_W'(2)) : (row == ROW_W'(1));
    ctl_next.bottom_clamp = ctl_next.emit_a ? last_item : (row == ROW_W'(IMAGE_SIZE));
    ctl_next.col          = col;
  end

  // Advance the frame position on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (last_item) begin
        row <= '0;
        col <= '0;
      end else if (col == COL_W'(IMAGE_SIZE - 1)) begin
        row <= row + ROW_W'(1);
        col <= '0;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Hold the request while the line memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= accept;
    end
    if (accept) begin
      ctl.pixel_part   <= ctl_next.pixel_part;
      ctl.last_item    <= ctl_next.last_item;
      ctl.emit_a       <= ctl_next.emit_a;
      ctl.emit_b       <= ctl_next.emit_b;
      ctl.col_one      <= ctl_next.col_one;
      ctl.top_clamp    <= ctl_next.top_clamp;
      ctl.bottom_clamp <= ctl_next.bottom_clamp;
      ctl.col          <= ctl_next.col;
      pixel.red        <= pix.in_red;
      pixel.green      <= pix.in_green;
      pixel.blue       <= pix.in_blue;
    end
  end

  // Both line stores share one entry: older row high, newer row low.
  // Of consecutive requests only a drain and the next share a column, and
  // a drain writes nothing, so no write-back meets a same-cycle read of it.
  assign wr_en   = en && ctl.valid && ctl.pixel_part;
  assign wr_data = {rd_data[23:0], pixel};

  bb3_line_ram #(
    .DEPTH (IMAGE_SIZE),
    .WIDTH (48)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ctl.col),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data)
  );

  bb3_window u_window (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctl    (ctl),
    .pixel  (pixel),
    .top    (rd_data[47:24]),
    .mid    (rd_data[23:0]),
    .taps   (taps)
  );

  bb3_average u_average (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .taps       (taps),
    .blur_valid (blur_valid),
    .blur       (blur)
  );

endmodule

`default_nettype wire

FILE: hdl/bb3_checker.sv
// Port-level checks for the box blur, bound to the top level.
// Depends on bb3_pkg.
`default_nettype none

module bb3_checker (
  input logic           clk,
  input logic           rst,
  input logic           pix_valid,
  input logic           pix_stall,
  input logic           blur_valid,
  input logic           blur_stall,
  input bb3_pkg::blur_t blur
);

  // A held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    blur_valid && blur_stall |=> blur_valid && $stable(blur))
    else $error("result changed while stalled");

  // Input is held back exactly when a finished result waits
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    pix_stall == (blur_valid && blur_stall))
    else $error("input stall does not follow the output register");

  // Nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !blur_valid)
    else $error("result valid after reset");

  // An empty output register never blocks the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !blur_valid |-> !pix_stall)
    else $error("input stalled with empty output");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);

`default_nettype wire
